// ===== hw/rtl/adrb_pkg.sv =====
package adrb_pkg;

	localparam int unsigned CNT_W   = 12;
	localparam int unsigned LIM_W   = 10;
	localparam int unsigned FC_W    = 32;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned WDATA_W = 10;

	localparam logic [3:0]       REQ_KEEP     = 4'd15;
	localparam logic [3:0]       POWER_LEVELS = 4'd8;
	localparam logic [3:0]       RATE_LEVELS  = 4'd6;
	localparam logic [2:0]       RATE_MAX     = 3'd5;
	localparam logic [CNT_W-1:0] ACK_CNT_MAX  = '1;

	typedef enum logic {
		FUNC_UPLINK   = 1'b0,
		FUNC_DOWNLINK = 1'b1
	} func_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_ADR_ENABLE      = 3'd0,
		CFG_ACK_LIMIT       = 3'd1,
		CFG_ACK_DELAY       = 3'd2,
		CFG_START_DATA_RATE = 3'd3,
		CFG_CONFIRMED_UP    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             adr_enable;
		logic [LIM_W-1:0] ack_limit;
		logic [LIM_W-1:0] ack_delay;
		logic [2:0]       start_data_rate;
		logic             confirmed_up;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic [2:0] rate;
	} rate_load_t;

	typedef struct packed {
		func_t      func;
		logic       has_link_adr_req;
		logic [3:0] req_data_rate;
		logic [3:0] req_tx_power;
		logic       confirmed_down;
	} in_item_t;

	typedef struct packed {
		logic [FC_W-1:0] frame_count;
		logic            adr_bit;
		logic            ack_bit;
		logic            adr_ack_req_bit;
		logic [2:0]      data_rate;
		logic [2:0]      tx_power;
		logic            ans_present;
		logic            ans_power_ack;
		logic            ans_rate_ack;
		logic            ans_mask_ack;
		logic            confirmed_frame;
	} out_item_t;

endpackage

// ===== hw/rtl/adrb_cfg.sv =====
module adrb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [adrb_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [adrb_pkg::WDATA_W-1:0]  cfg_wdata,
	output adrb_pkg::cfg_t                cfg,
	output adrb_pkg::rate_load_t          rate_load
);

	adrb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adr_enable      <= 1'b1;
			cfg_q.ack_limit       <= 10'd64;
			cfg_q.ack_delay       <= 10'd32;
			cfg_q.start_data_rate <= 3'd0;
			cfg_q.confirmed_up    <= 1'b0;
		end else if (cfg_we) begin
			unique case (adrb_pkg::cfg_idx_t'(cfg_idx))
				adrb_pkg::CFG_ADR_ENABLE:      cfg_q.adr_enable      <= cfg_wdata[0];
				adrb_pkg::CFG_ACK_LIMIT:       cfg_q.ack_limit       <= cfg_wdata;
				adrb_pkg::CFG_ACK_DELAY:       cfg_q.ack_delay       <= cfg_wdata;
				adrb_pkg::CFG_START_DATA_RATE: cfg_q.start_data_rate <= cfg_wdata[2:0];
				adrb_pkg::CFG_CONFIRMED_UP:    cfg_q.confirmed_up    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// a start rate above the top rate is stored but not loaded
	always_comb begin
		rate_load.load = cfg_we
			&& (adrb_pkg::cfg_idx_t'(cfg_idx) == adrb_pkg::CFG_START_DATA_RATE)
			&& (cfg_wdata[2:0] <= adrb_pkg::RATE_MAX);
		rate_load.rate = cfg_wdata[2:0];
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/adrb_core.sv =====
module adrb_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adrb_pkg::cfg_t       cfg,
	input  adrb_pkg::rate_load_t rate_load,
	input  logic                 step,
	input  adrb_pkg::in_item_t   item,
	output adrb_pkg::out_item_t  res
);

	logic [adrb_pkg::FC_W-1:0]  frame_q,  frame_d;
	logic [adrb_pkg::CNT_W-1:0] cnt_q,    cnt_d, cnt_inc;
	logic                       req_q,    req_d;
	logic [2:0]                 rate_q,   rate_d;
	logic [2:0]                 power_q,  power_d;
	logic                       pend_q,   pend_d;
	logic                       ans_q,    ans_d;
	logic                       pw_ok_q,  pw_ok_d;
	logic                       dr_ok_q,  dr_ok_d;
	logic                       m_ok_q,   m_ok_d;
	logic [adrb_pkg::CNT_W-1:0] lim, win_end;
	logic                       ack_out, ans_p, ans_pw, ans_dr, ans_m;

	assign lim     = adrb_pkg::CNT_W'(cfg.ack_limit);
	assign win_end = adrb_pkg::CNT_W'({1'b0, cfg.ack_limit} + {1'b0, cfg.ack_delay});
	assign cnt_inc = (cnt_q < adrb_pkg::ACK_CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		frame_d = frame_q;
		cnt_d   = cnt_q;
		req_d   = req_q;
		rate_d  = rate_q;
		power_d = power_q;
		pend_d  = pend_q;
		ans_d   = ans_q;
		pw_ok_d = pw_ok_q;
		dr_ok_d = dr_ok_q;
		m_ok_d  = m_ok_q;
		ack_out = 1'b0;
		ans_p   = 1'b0;
		ans_pw  = 1'b0;
		ans_dr  = 1'b0;
		ans_m   = 1'b0;
		unique case (item.func)
			adrb_pkg::FUNC_UPLINK: begin
				ack_out = pend_q;
				ans_p   = ans_q;
				ans_pw  = ans_q & pw_ok_q;
				ans_dr  = ans_q & dr_ok_q;
				ans_m   = ans_q & m_ok_q;
				ans_d   = 1'b0;
				pw_ok_d = 1'b0;
				dr_ok_d = 1'b0;
				m_ok_d  = 1'b0;
				frame_d = frame_q + 1'b1;
				pend_d  = 1'b0;
				if (cfg.adr_enable) begin
					cnt_d = cnt_inc;
					if (power_q != 3'd0 || rate_q != 3'd0) begin
						priority if (cnt_inc == lim) begin
							req_d = 1'b1;
						end else if (cnt_inc == win_end) begin
							if (power_q != 3'd0) begin
								power_d = 3'd0;
							end else begin
								rate_d = rate_q - 1'b1;
							end
							cnt_d = lim;
						end
					end else begin
						req_d = 1'b0;
					end
				end
			end
			adrb_pkg::FUNC_DOWNLINK: begin
				if (cfg.adr_enable) begin
					cnt_d = '0;
					req_d = 1'b0;
				end
				if (item.has_link_adr_req) begin
					if (item.req_data_rate < adrb_pkg::RATE_LEVELS) begin
						rate_d  = item.req_data_rate[2:0];
						dr_ok_d = 1'b1;
					end else begin
						dr_ok_d = (item.req_data_rate == adrb_pkg::REQ_KEEP);
					end
					if (item.req_tx_power < adrb_pkg::POWER_LEVELS) begin
						power_d = item.req_tx_power[2:0];
						pw_ok_d = 1'b1;
					end else begin
						pw_ok_d = (item.req_tx_power == adrb_pkg::REQ_KEEP);
					end
					m_ok_d = 1'b1;
					ans_d  = 1'b1;
				end
				if (item.confirmed_down) begin
					pend_d = 1'b1;
				end
				ack_out = pend_d;
				ans_p   = ans_d;
				ans_pw  = pw_ok_d;
				ans_dr  = dr_ok_d;
				ans_m   = m_ok_d;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			cnt_q   <= '0;
			req_q   <= 1'b0;
			rate_q  <= 3'd0;
			power_q <= 3'd0;
			pend_q  <= 1'b0;
			ans_q   <= 1'b0;
			pw_ok_q <= 1'b0;
			dr_ok_q <= 1'b0;
			m_ok_q  <= 1'b0;
		end else if (step) begin
			frame_q <= frame_d;
			cnt_q   <= cnt_d;
			req_q   <= req_d;
			rate_q  <= rate_d;
			power_q <= power_d;
			pend_q  <= pend_d;
			ans_q   <= ans_d;
			pw_ok_q <= pw_ok_d;
			dr_ok_q <= dr_ok_d;
			m_ok_q  <= m_ok_d;
		end else if (rate_load.load) begin
			rate_q <= rate_load.rate;
		end
	end

	always_comb begin
		res.frame_count     = frame_d;
		res.adr_bit         = cfg.adr_enable;
		res.ack_bit         = ack_out;
		res.adr_ack_req_bit = req_d;
		res.data_rate       = rate_d;
		res.tx_power        = power_d;
		res.ans_present     = ans_p;
		res.ans_power_ack   = ans_pw;
		res.ans_rate_ack    = ans_dr;
		res.ans_mask_ack    = ans_m;
		res.confirmed_frame = cfg.confirmed_up;
	end

endmodule

// ===== hw/rtl/lorawan_device_adr_backoff_top.sv =====
// LoRaWAN end-device ADR controller with acknowledge back-off. One result per
// item; an item passes from input transfer to result through the input register,
// then the state update into the result register. A new item is taken every
// cycle unless the input side stalls, which happens only when both the input
// and the output register are full and the output is not being taken.
// Config writes are registered and must be issued only while the block is
// idle; writing start_data_rate with a value above 5 does not move the rate.
module lorawan_device_adr_backoff_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [adrb_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [adrb_pkg::WDATA_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  adrb_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output adrb_pkg::out_item_t           out_item
);

	adrb_pkg::cfg_t       cfg;
	adrb_pkg::rate_load_t rate_load;
	adrb_pkg::in_item_t   item_s1;
	adrb_pkg::out_item_t  res, res_s2;
	logic                 valid_s1, valid_s2;
	logic                 advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	adrb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.rate_load (rate_load)
	);

	adrb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rate_load (rate_load),
		.step      (valid_s1 && advance),
		.item      (item_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

`ifndef NO_ASSERTIONS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are stalled");

	a_step_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid)
		else $error("processed item did not reach the output");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.data_rate <= adrb_pkg::RATE_MAX))
		else $error("data rate out of range");
`endif

endmodule

// ===== verif/lorawan_device_adr_backoff_top_tb.sv =====
`timescale 1ns / 1ps

module lorawan_device_adr_backoff_top_tb;

	typedef logic [adrb_pkg::FC_W-1:0] word_t;

	localparam int unsigned                 WATCHDOG_LIMIT   = 5000;
	localparam int unsigned                 HOLD_OFF_CYCLES  = 250;
	localparam int unsigned                 SETTLE_CYCLES    = 8;
	localparam int unsigned                 RANDOM_PHASES    = 10;
	localparam int unsigned                 PHASE_ITEMS      = 65;
	localparam int unsigned                 MISMATCH_REPORTS = 10;
	localparam logic [adrb_pkg::IDX_W-1:0]  CFG_NO_REG       = 3'd7;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_we    = 1'b0;
	logic [adrb_pkg::IDX_W-1:0]       cfg_idx   = '0;
	logic [adrb_pkg::WDATA_W-1:0]     cfg_wdata = '0;
	logic                             in_valid  = 1'b0;
	logic                             in_ready;
	adrb_pkg::in_item_t               in_item   = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	adrb_pkg::out_item_t              out_item;

	lorawan_device_adr_backoff_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// device shadow
	adrb_pkg::cfg_t                   dev_cfg = '{1'b1, 10'd64, 10'd32, 3'd0, 1'b0};
	logic [adrb_pkg::FC_W-1:0]        dev_fcnt     = '0;
	logic [adrb_pkg::CNT_W-1:0]       dev_ack_cnt  = '0;
	logic                             dev_ack_req  = 1'b0;
	logic [2:0]                       dev_rate     = '0;
	logic [2:0]                       dev_power    = '0;
	logic                             dev_ack_owed = 1'b0;
	logic                             dev_ans_owed = 1'b0;
	logic                             dev_power_ok = 1'b0;
	logic                             dev_rate_ok  = 1'b0;
	logic                             dev_mask_ok  = 1'b0;

	adrb_pkg::in_item_t  pending_events[$];
	adrb_pkg::out_item_t expected_frames[$];

	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	int unsigned uplink_pct   = 85;
	int unsigned hold_left    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_count     = 0;
	int unsigned mismatches   = 0;
	int unsigned n_up         = 0;
	int unsigned n_down       = 0;
	int unsigned n_link_req   = 0;
	int unsigned n_steps      = 0;
	int unsigned n_profiles   = 0;

	function automatic adrb_pkg::out_item_t advance_device(input adrb_pkg::in_item_t ev);
		adrb_pkg::out_item_t        r;
		logic [adrb_pkg::CNT_W-1:0] lim;
		logic [adrb_pkg::CNT_W-1:0] win_end;
		r       = '0;
		lim     = {2'b00, dev_cfg.ack_limit};
		win_end = lim + {2'b00, dev_cfg.ack_delay};
		if (ev.func == adrb_pkg::FUNC_UPLINK) begin
			r.ack_bit       = dev_ack_owed;
			r.ans_present   = dev_ans_owed;
			r.ans_power_ack = dev_ans_owed & dev_power_ok;
			r.ans_rate_ack  = dev_ans_owed & dev_rate_ok;
			r.ans_mask_ack  = dev_ans_owed & dev_mask_ok;
			dev_ans_owed = 1'b0;
			dev_power_ok = 1'b0;
			dev_rate_ok  = 1'b0;
			dev_mask_ok  = 1'b0;
			dev_fcnt     = dev_fcnt + 1'b1;
			if (dev_cfg.adr_enable) begin
				if (dev_ack_cnt != adrb_pkg::ACK_CNT_MAX)
					dev_ack_cnt = dev_ack_cnt + 1'b1;
				if (dev_power != 3'd0 || dev_rate != 3'd0) begin
					if (dev_ack_cnt == lim) begin
						dev_ack_req = 1'b1;
					end else if (dev_ack_cnt == win_end) begin
						if (dev_power != 3'd0)
							dev_power = '0;
						else
							dev_rate = dev_rate - 3'd1;
						dev_ack_cnt = lim;
						n_steps++;
					end
				end else begin
					dev_ack_req = 1'b0;
				end
			end
			dev_ack_owed = 1'b0;
		end else begin
			if (dev_cfg.adr_enable) begin
				dev_ack_cnt = '0;
				dev_ack_req = 1'b0;
			end
			if (ev.has_link_adr_req) begin
				if (ev.req_data_rate < adrb_pkg::RATE_LEVELS) begin
					dev_rate    = ev.req_data_rate[2:0];
					dev_rate_ok = 1'b1;
				end else begin
					dev_rate_ok = (ev.req_data_rate == adrb_pkg::REQ_KEEP);
				end
				if (ev.req_tx_power < adrb_pkg::POWER_LEVELS) begin
					dev_power    = ev.req_tx_power[2:0];
					dev_power_ok = 1'b1;
				end else begin
					dev_power_ok = (ev.req_tx_power == adrb_pkg::REQ_KEEP);
				end
				dev_mask_ok  = 1'b1;
				dev_ans_owed = 1'b1;
			end
			if (ev.confirmed_down)
				dev_ack_owed = 1'b1;
			r.ack_bit       = dev_ack_owed;
			r.ans_present   = dev_ans_owed;
			r.ans_power_ack = dev_power_ok;
			r.ans_rate_ack  = dev_rate_ok;
			r.ans_mask_ack  = dev_mask_ok;
		end
		r.frame_count     = dev_fcnt;
		r.adr_bit         = dev_cfg.adr_enable;
		r.adr_ack_req_bit = dev_ack_req;
		r.data_rate       = dev_rate;
		r.tx_power        = dev_power;
		r.confirmed_frame = dev_cfg.confirmed_up;
		return r;
	endfunction

	task automatic report_field(input string field, input word_t want, input word_t got);
		mismatches++;
		if (mismatches <= MISMATCH_REPORTS)
			$display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
				$realtime, rx_count, field, want, got);
	endtask

	task automatic check_frame(input adrb_pkg::out_item_t want,
			input adrb_pkg::out_item_t got);
		if (got.frame_count !== want.frame_count)
			report_field("frame_count", want.frame_count, got.frame_count);
		if (got.adr_bit !== want.adr_bit)
			report_field("adr_bit", word_t'(want.adr_bit), word_t'(got.adr_bit));
		if (got.ack_bit !== want.ack_bit)
			report_field("ack_bit", word_t'(want.ack_bit), word_t'(got.ack_bit));
		if (got.adr_ack_req_bit !== want.adr_ack_req_bit)
			report_field("adr_ack_req_bit", word_t'(want.adr_ack_req_bit),
				word_t'(got.adr_ack_req_bit));
		if (got.data_rate !== want.data_rate)
			report_field("data_rate", word_t'(want.data_rate), word_t'(got.data_rate));
		if (got.tx_power !== want.tx_power)
			report_field("tx_power", word_t'(want.tx_power), word_t'(got.tx_power));
		if (got.ans_present !== want.ans_present)
			report_field("ans_present", word_t'(want.ans_present),
				word_t'(got.ans_present));
		if (got.ans_power_ack !== want.ans_power_ack)
			report_field("ans_power_ack", word_t'(want.ans_power_ack),
				word_t'(got.ans_power_ack));
		if (got.ans_rate_ack !== want.ans_rate_ack)
			report_field("ans_rate_ack", word_t'(want.ans_rate_ack),
				word_t'(got.ans_rate_ack));
		if (got.ans_mask_ack !== want.ans_mask_ack)
			report_field("ans_mask_ack", word_t'(want.ans_mask_ack),
				word_t'(got.ans_mask_ack));
		if (got.confirmed_frame !== want.confirmed_frame)
			report_field("confirmed_frame", word_t'(want.confirmed_frame),
				word_t'(got.confirmed_frame));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_frames.push_back(advance_device(in_item));
				if (in_item.func == adrb_pkg::FUNC_UPLINK) begin
					n_up++;
				end else begin
					n_down++;
					if (in_item.has_link_adr_req)
						n_link_req++;
				end
			end
			if (!in_valid || in_ready) begin
				if (pending_events.size() != 0
						&& !(send_idle_on && $urandom_range(99) < 9)) begin
					in_valid <= 1'b1;
					in_item  <= pending_events.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rx_count++;
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_REPORTS)
						$display("[%0t] unexpected result %0d, frame_count 0x%0h",
							$realtime, rx_count, out_item.frame_count);
				end else begin
					check_frame(expected_frames.pop_front(), out_item);
				end
				// long receiver hold-off so the pipe backs up into the input
				if (rx_count % 700 == 350)
					hold_left = HOLD_OFF_CYCLES;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_ready <= (hold_left == 0) && !(recv_idle_on && $urandom_range(99) < 9);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [adrb_pkg::IDX_W-1:0] idx,
			input logic [adrb_pkg::WDATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			adrb_pkg::CFG_ADR_ENABLE: dev_cfg.adr_enable = val[0];
			adrb_pkg::CFG_ACK_LIMIT:  dev_cfg.ack_limit  = val[adrb_pkg::LIM_W-1:0];
			adrb_pkg::CFG_ACK_DELAY:  dev_cfg.ack_delay  = val[adrb_pkg::LIM_W-1:0];
			adrb_pkg::CFG_START_DATA_RATE: begin
				dev_cfg.start_data_rate = val[2:0];
				if (val[2:0] <= adrb_pkg::RATE_MAX)
					dev_rate = val[2:0];
			end
			adrb_pkg::CFG_CONFIRMED_UP: dev_cfg.confirmed_up = val[0];
			default: ;
		endcase
	endtask

	task automatic set_profile(input bit en, input int unsigned lim, input int unsigned dly,
			input int unsigned rate, input bit conf);
		n_profiles++;
		write_reg(adrb_pkg::CFG_ADR_ENABLE, adrb_pkg::WDATA_W'(en));
		write_reg(adrb_pkg::CFG_ACK_LIMIT, adrb_pkg::WDATA_W'(lim));
		write_reg(adrb_pkg::CFG_ACK_DELAY, adrb_pkg::WDATA_W'(dly));
		write_reg(adrb_pkg::CFG_START_DATA_RATE, adrb_pkg::WDATA_W'(rate));
		write_reg(adrb_pkg::CFG_CONFIRMED_UP, adrb_pkg::WDATA_W'(conf));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic adrb_pkg::in_item_t uplink_event();
		adrb_pkg::in_item_t ev;
		ev.func             = adrb_pkg::FUNC_UPLINK;
		ev.has_link_adr_req = 1'($urandom_range(1));
		ev.req_data_rate    = 4'($urandom_range(15));
		ev.req_tx_power     = 4'($urandom_range(15));
		ev.confirmed_down   = 1'($urandom_range(1));
		return ev;
	endfunction

	function automatic adrb_pkg::in_item_t downlink_event(input bit has_req,
			input logic [3:0] dr, input logic [3:0] tx, input bit conf);
		adrb_pkg::in_item_t ev;
		ev.func             = adrb_pkg::FUNC_DOWNLINK;
		ev.has_link_adr_req = has_req;
		ev.req_data_rate    = dr;
		ev.req_tx_power     = tx;
		ev.confirmed_down   = conf;
		return ev;
	endfunction

	function automatic adrb_pkg::in_item_t random_event();
		adrb_pkg::in_item_t ev;
		int unsigned        pick;
		if ($urandom_range(99) < uplink_pct)
			return uplink_event();
		ev.func             = adrb_pkg::FUNC_DOWNLINK;
		ev.has_link_adr_req = ($urandom_range(99) < 70);
		ev.confirmed_down   = 1'($urandom_range(1));
		pick = $urandom_range(99);
		ev.req_data_rate = (pick < 75) ? 4'($urandom_range(5)) :
			(pick < 85) ? adrb_pkg::REQ_KEEP : 4'($urandom_range(15));
		pick = $urandom_range(99);
		ev.req_tx_power = (pick < 75) ? 4'($urandom_range(7)) :
			(pick < 85) ? adrb_pkg::REQ_KEEP : 4'($urandom_range(15));
		return ev;
	endfunction

	function automatic int unsigned pick_window();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return $urandom_range(6, 1);
		if (pick < 80)
			return 0;
		if (pick < 88)
			return 1023;
		return $urandom_range(1023);
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// request at limit, step back at limit plus delay, answer flags, refused values
		set_profile(1'b1, 2, 3, 5, 1'b1);
		repeat (5) pending_events.push_back(uplink_event());
		pending_events.push_back(downlink_event(1'b1, adrb_pkg::REQ_KEEP,
			adrb_pkg::REQ_KEEP, 1'b1));
		pending_events.push_back(uplink_event());
		pending_events.push_back(downlink_event(1'b1, 4'd6, 4'd8, 1'b0));
		pending_events.push_back(downlink_event(1'b1, 4'd14, 4'd14, 1'b0));
		pending_events.push_back(downlink_event(1'b1, 4'd3, 4'd7, 1'b0));
		pending_events.push_back(uplink_event());
		pending_events.push_back(downlink_event(1'b1, 4'd0, 4'd0, 1'b1));
		pending_events.push_back(uplink_event());
		pending_events.push_back(downlink_event(1'b0, 4'd5, 4'd2, 1'b0));
		pending_events.push_back(downlink_event(1'b1, 4'd5, 4'd2, 1'b0));
		repeat (5) pending_events.push_back(uplink_event());
		wait_drained();

		// ADR off: downlink leaves counter and request alone
		set_profile(1'b0, 1, 1, 0, 1'b0);
		pending_events.push_back(downlink_event(1'b1, 4'd2, 4'd3, 1'b1));
		repeat (2) pending_events.push_back(uplink_event());
		wait_drained();

		// zero delay: request wins, no step back; start rate above 5 ignored
		set_profile(1'b1, 3, 0, 6, 1'b1);
		pending_events.push_back(downlink_event(1'b1, 4'd4, 4'd1, 1'b0));
		repeat (5) pending_events.push_back(uplink_event());
		wait_drained();

		set_profile(1'b1, 0, 2, 7, 1'b0);
		write_reg(CFG_NO_REG, '1);
		pending_events.push_back(downlink_event(1'b0, 4'd0, 4'd0, 1'b0));
		repeat (3) pending_events.push_back(uplink_event());
		wait_drained();

		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			set_profile($urandom_range(9) != 0, pick_window(), pick_window(),
				$urandom_range(7), 1'($urandom_range(1)));
			if (p == 2)
				set_profile(1'b1, 1, 1, 5, 1'b1);
			uplink_pct   = $urandom_range(97, 70);
			send_idle_on = (p != 3);
			recv_idle_on = (p != 3);
			repeat (PHASE_ITEMS) pending_events.push_back(random_event());
			wait_drained();
		end

		// widest limit, back to back
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		set_profile(1'b1, 1023, 100, 5, 1'b0);
		repeat (1130) pending_events.push_back(uplink_event());
		wait_drained();
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;

		// best link clears the request, then move the rate
		set_profile(1'b1, 1023, 1023, 0, 1'b1);
		pending_events.push_back(downlink_event(1'b1, 4'd0, 4'd0, 1'b0));
		repeat (5) pending_events.push_back(uplink_event());
		wait_drained();
		write_reg(adrb_pkg::CFG_START_DATA_RATE, 10'd2);
		write_reg(adrb_pkg::CFG_ACK_LIMIT, 10'd3);
		repeat (20) pending_events.push_back(uplink_event());
		wait_drained();

		$display("Run covered %0d uplinks and %0d downlinks (%0d link ADR requests) over %0d",
			n_up, n_down, n_link_req, n_profiles);
		$display("register settings, with %0d power/rate step-backs; %0d results checked",
			n_steps, rx_count);
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_frames.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
